>>> rtl/core/vertex_store_transform_assert.svh
// assertion macros for the vertex store transform block
// expects clk and rst in the scope of use
`ifndef VERTEX_STORE_TRANSFORM_ASSERT_SVH
`define VERTEX_STORE_TRANSFORM_ASSERT_SVH

// same-cycle implication, off during reset
`define VST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define VST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/vst_pkg.sv
// shared types, constants and arithmetic helpers of the vertex store transform
// no dependencies
package vst_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int IN_W         = 144;
  localparam int OUT_W        = 112;

  // operation codes
  localparam logic [2:0] FN_APPEND    = 3'd0;
  localparam logic [2:0] FN_COPY      = 3'd1;
  localparam logic [2:0] FN_READ      = 3'd2;
  localparam logic [2:0] FN_TRANSLATE = 3'd3;
  localparam logic [2:0] FN_SCALE     = 3'd4;
  localparam logic [2:0] FN_ROTATE    = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ID  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SC, S_Q1, S_Q2, S_Q3, S_MAT,
    S_R0, S_R1, S_R2, S_R3, S_COMMIT
  } state_t;

  // operand selection of the three shared multipliers
  typedef enum logic [2:0] {
    MS_SQR, MS_CROSS, MS_W, MS_SCALE, MS_ROW0, MS_ROW1, MS_ROW2
  } mul_sel_t;

  // which register group takes a result
  typedef enum logic [3:0] {
    CAP_NONE, CAP_SIMPLE, CAP_SCALE, CAP_SQR, CAP_CROSS, CAP_W,
    CAP_X, CAP_Y, CAP_Z
  } cap_t;

  typedef struct packed {
    logic     accept;
    mul_sel_t mul_sel;
    cap_t     cap;
    logic     build_mat;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic       err;
    logic [2:0] func;
    logic       out_busy;
  } sts_t;

  // rounded fixed-point value of a raw product, round half up
  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    logic signed [63:0] half;
    half = 64'sd1 <<< (FRAC_BITS - 1);
    return (p + half) >>> FRAC_BITS;
  endfunction

  // saturate to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

>>> rtl/core/vertex_store_transform.sv
// vertex store transform: append, copy, read, translate and errors go from accept
// through dispatch to commit; scale adds a multiply step, rotate adds quaternion
// products, matrix build and three row passes through three shared 32x32 multipliers
// one item at a time: next item accepted the cycle after its result is registered
// reset (synchronous) clears the vertex count and the output valid flag; the table
// is not cleared and needs no clearing pass
module vertex_store_transform (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // func, vtx_index, param_a, param_b, param_c, param_d, zero pad
  input  logic [vst_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status, result_id, out_x, out_y, out_z, zero pad
  output logic [vst_pkg::OUT_W-1:0] m_tdata
);

  vst_pkg::cmd_t cmd;
  vst_pkg::sts_t sts;

  // sequencer
  vst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and arithmetic
  vst_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

>>> rtl/core/vst_ctrl.sv
// controller state machine of the vertex store transform
// depends on vst_pkg
module vst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  vst_pkg::sts_t  sts,
  output vst_pkg::cmd_t  cmd
);

  vst_pkg::state_t state;
  vst_pkg::state_t state_next;
  logic            simple;

  assign simple = sts.err || (sts.func != vst_pkg::FN_SCALE && sts.func != vst_pkg::FN_ROTATE);
  assign s_tready = (state == vst_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= vst_pkg::S_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vst_pkg::S_IDLE:     if (s_tvalid) state_next = vst_pkg::S_DISPATCH;
      vst_pkg::S_DISPATCH: begin
        if (simple) state_next = vst_pkg::S_COMMIT;
        else if (sts.func == vst_pkg::FN_SCALE) state_next = vst_pkg::S_SC;
        else state_next = vst_pkg::S_Q1;
      end
      vst_pkg::S_SC:       state_next = vst_pkg::S_COMMIT;
      vst_pkg::S_Q1:       state_next = vst_pkg::S_Q2;
      vst_pkg::S_Q2:       state_next = vst_pkg::S_Q3;
      vst_pkg::S_Q3:       state_next = vst_pkg::S_MAT;
      vst_pkg::S_MAT:      state_next = vst_pkg::S_R0;
      vst_pkg::S_R0:       state_next = vst_pkg::S_R1;
      vst_pkg::S_R1:       state_next = vst_pkg::S_R2;
      vst_pkg::S_R2:       state_next = vst_pkg::S_R3;
      vst_pkg::S_R3:       state_next = vst_pkg::S_COMMIT;
      vst_pkg::S_COMMIT:   if (!sts.out_busy) state_next = vst_pkg::S_IDLE;
      default:             state_next = vst_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = vst_pkg::MS_SQR;
    cmd.cap       = vst_pkg::CAP_NONE;
    case (state)
      vst_pkg::S_IDLE:     cmd.accept = s_tvalid;
      vst_pkg::S_DISPATCH: begin
        if (simple) cmd.cap = vst_pkg::CAP_SIMPLE;
        else if (sts.func == vst_pkg::FN_SCALE) cmd.mul_sel = vst_pkg::MS_SCALE;
        else cmd.mul_sel = vst_pkg::MS_SQR;
      end
      vst_pkg::S_SC:       cmd.cap = vst_pkg::CAP_SCALE;
      vst_pkg::S_Q1: begin
        cmd.mul_sel = vst_pkg::MS_CROSS;
        cmd.cap     = vst_pkg::CAP_SQR;
      end
      vst_pkg::S_Q2: begin
        cmd.mul_sel = vst_pkg::MS_W;
        cmd.cap     = vst_pkg::CAP_CROSS;
      end
      vst_pkg::S_Q3:       cmd.cap = vst_pkg::CAP_W;
      vst_pkg::S_MAT:      cmd.build_mat = 1'b1;
      vst_pkg::S_R0:       cmd.mul_sel = vst_pkg::MS_ROW0;
      vst_pkg::S_R1: begin
        cmd.mul_sel = vst_pkg::MS_ROW1;
        cmd.cap     = vst_pkg::CAP_X;
      end
      vst_pkg::S_R2: begin
        cmd.mul_sel = vst_pkg::MS_ROW2;
        cmd.cap     = vst_pkg::CAP_Y;
      end
      vst_pkg::S_R3:       cmd.cap = vst_pkg::CAP_Z;
      vst_pkg::S_COMMIT:   cmd.commit = !sts.out_busy;
      default:             cmd.accept = 1'b0;
    endcase
  end

`include "vertex_store_transform_assert.svh"

  `VST_ASSERT_NXT(a_accept_dispatch, cmd.accept, state == vst_pkg::S_DISPATCH, "accept not followed by dispatch")
  `VST_ASSERT_IMP(a_commit_free, cmd.commit, !sts.out_busy, "commit while output occupied")
  `VST_ASSERT_IMP(a_ready_idle, s_tready, !cmd.commit && cmd.cap == vst_pkg::CAP_NONE, "ready while busy")

endmodule

>>> rtl/core/vst_datapath.sv
// datapath: vertex table, three shared multipliers, matrix and output register
// depends on vst_pkg
module vst_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [vst_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [vst_pkg::OUT_W-1:0]  m_tdata,
  input  vst_pkg::cmd_t              cmd,
  output vst_pkg::sts_t              sts
);

  localparam logic signed [63:0] ONE = 64'sd1 <<< vst_pkg::FRAC_BITS;

  // vertex table, x in the low word
  logic [95:0] mem [vst_pkg::MAX_VERTICES];
  logic [95:0] rd;

  logic [vst_pkg::CNT_W-1:0]  count;
  logic [2:0]                 func;
  logic [vst_pkg::ADDR_W-1:0] id;
  logic signed [31:0]         pa, pb, pc, pd;
  logic [1:0]                 status;
  logic signed [31:0]         tx, ty, tz;
  logic signed [31:0]         nx, ny, nz;
  logic signed [63:0]         xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [31:0]         m [9];
  logic signed [31:0]         op_a [3];
  logic signed [31:0]         op_b [3];
  logic signed [63:0]         prod [3];
  logic signed [63:0]         r0, r1, r2;

  // decode of the incoming beat
  logic [2:0]                 in_func;
  logic [vst_pkg::ADDR_W-1:0] in_id;
  logic                       in_valid;
  logic                       in_full;
  logic [1:0]                 in_status;

  assign in_func  = s_tdata[2:0];
  assign in_id    = s_tdata[12:3];
  assign in_valid = {1'b0, in_id} < count;
  assign in_full  = count == vst_pkg::CNT_W'(vst_pkg::MAX_VERTICES);

  always_comb begin
    in_status = vst_pkg::ST_OK;
    case (in_func)
      vst_pkg::FN_APPEND: if (in_full) in_status = vst_pkg::ST_FULL;
      vst_pkg::FN_COPY: begin
        if (!in_valid) in_status = vst_pkg::ST_BAD_ID;
        else if (in_full) in_status = vst_pkg::ST_FULL;
      end
      vst_pkg::FN_READ, vst_pkg::FN_TRANSLATE, vst_pkg::FN_SCALE, vst_pkg::FN_ROTATE:
        if (!in_valid) in_status = vst_pkg::ST_BAD_ID;
      default: in_status = vst_pkg::ST_BAD_ID;
    endcase
  end

  // input registers and table read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func   <= in_func;
      id     <= in_id;
      pa     <= s_tdata[44:13];
      pb     <= s_tdata[76:45];
      pc     <= s_tdata[108:77];
      pd     <= s_tdata[140:109];
      status <= in_status;
      rd     <= mem[in_id];
    end
  end

  assign tx = rd[31:0];
  assign ty = rd[63:32];
  assign tz = rd[95:64];

  // operand selection
  always_comb begin
    op_a = '{tx, ty, tz};
    op_b = '{pa, pb, pc};
    case (cmd.mul_sel)
      vst_pkg::MS_SQR: begin
        op_a = '{pa, pb, pc};
        op_b = '{pa, pb, pc};
      end
      vst_pkg::MS_CROSS: begin
        op_a = '{pa, pa, pb};
        op_b = '{pb, pc, pc};
      end
      vst_pkg::MS_W: begin
        op_a = '{pa, pb, pc};
        op_b = '{pd, pd, pd};
      end
      vst_pkg::MS_SCALE: op_b = '{pa, pb, pc};
      vst_pkg::MS_ROW0:  op_b = '{m[0], m[1], m[2]};
      vst_pkg::MS_ROW1:  op_b = '{m[3], m[4], m[5]};
      vst_pkg::MS_ROW2:  op_b = '{m[6], m[7], m[8]};
      default:           op_b = '{pa, pb, pc};
    endcase
  end

  // shared multipliers, registered products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= 64'(op_a[i]) * 64'(op_b[i]);
    end
  end

  assign r0 = vst_pkg::rnd(prod[0]);
  assign r1 = vst_pkg::rnd(prod[1]);
  assign r2 = vst_pkg::rnd(prod[2]);

  // quaternion products
  always_ff @(posedge clk) begin
    case (cmd.cap)
      vst_pkg::CAP_SQR: begin
        xx <= r0; yy <= r1; zz <= r2;
      end
      vst_pkg::CAP_CROSS: begin
        xy <= r0; xz <= r1; yz <= r2;
      end
      vst_pkg::CAP_W: begin
        xw <= r0; yw <= r1; zw <= r2;
      end
      default: xx <= xx;
    endcase
  end

  // rotation matrix
  always_ff @(posedge clk) begin
    if (cmd.build_mat) begin
      m[0] <= vst_pkg::sat32(ONE - 2 * (yy + zz));
      m[1] <= vst_pkg::sat32(2 * (xy - zw));
      m[2] <= vst_pkg::sat32(2 * (xz + yw));
      m[3] <= vst_pkg::sat32(2 * (xy + zw));
      m[4] <= vst_pkg::sat32(ONE - 2 * (xx + zz));
      m[5] <= vst_pkg::sat32(2 * (yz - xw));
      m[6] <= vst_pkg::sat32(2 * (xz - yw));
      m[7] <= vst_pkg::sat32(2 * (yz + xw));
      m[8] <= vst_pkg::sat32(ONE - 2 * (xx + yy));
    end
  end

  // new coordinates
  always_ff @(posedge clk) begin
    case (cmd.cap)
      vst_pkg::CAP_SIMPLE: begin
        if (status != vst_pkg::ST_OK) begin
          nx <= '0; ny <= '0; nz <= '0;
        end else if (func == vst_pkg::FN_APPEND) begin
          nx <= pa; ny <= pb; nz <= pc;
        end else if (func == vst_pkg::FN_TRANSLATE) begin
          nx <= vst_pkg::sat32(64'(tx) + 64'(pa));
          ny <= vst_pkg::sat32(64'(ty) + 64'(pb));
          nz <= vst_pkg::sat32(64'(tz) + 64'(pc));
        end else begin
          nx <= tx; ny <= ty; nz <= tz;
        end
      end
      vst_pkg::CAP_SCALE: begin
        nx <= vst_pkg::sat32(r0);
        ny <= vst_pkg::sat32(r1);
        nz <= vst_pkg::sat32(r2);
      end
      vst_pkg::CAP_X: nx <= vst_pkg::sat32(r0 + r1 + r2);
      vst_pkg::CAP_Y: ny <= vst_pkg::sat32(r0 + r1 + r2);
      vst_pkg::CAP_Z: nz <= vst_pkg::sat32(r0 + r1 + r2);
      default: nx <= nx;
    endcase
  end

  // commit: table write and result
  logic                       is_new;
  logic [vst_pkg::ADDR_W-1:0] waddr;
  logic                       ok;

  assign is_new = func == vst_pkg::FN_APPEND || func == vst_pkg::FN_COPY;
  assign waddr  = is_new ? count[vst_pkg::ADDR_W-1:0] : id;
  assign ok     = status == vst_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (cmd.commit && ok) mem[waddr] <= {nz, ny, nx};
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.commit && ok && is_new) count <= count + 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.commit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {4'd0, nz, ny, nx, (ok ? waddr : id), status};
    end
  end

  assign sts.err      = !ok;
  assign sts.func     = func;
  assign sts.out_busy = m_tvalid && !m_tready;

`include "vertex_store_transform_assert.svh"

  `VST_ASSERT_NXT(a_commit_valid, cmd.commit, m_tvalid, "result not shown after commit")
  `VST_ASSERT_IMP(a_count_max, 1'b1, count <= vst_pkg::CNT_W'(vst_pkg::MAX_VERTICES), "count overflow")
  `VST_ASSERT_NXT(a_count_hold, !cmd.commit, $stable(count), "count moved without commit")

endmodule

>>> test/tb_vertex_store_transform.sv
// testbench for the vertex store transform: directed and random vertex operations
// depends on vst_pkg and vertex_store_transform; predicts each result beat in place
`timescale 1ns / 1ps

module tb_vertex_store_transform;

  // status ends up in the lowest bits, z in the highest
  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [9:0]  rid;
    logic [1:0]  status;
  } vtx_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [vst_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [vst_pkg::OUT_W-1:0] m_tdata;

  // model state of the table
  logic signed [31:0] tab_x [vst_pkg::MAX_VERTICES];
  logic signed [31:0] tab_y [vst_pkg::MAX_VERTICES];
  logic signed [31:0] tab_z [vst_pkg::MAX_VERTICES];
  int unsigned vcount;

  vtx_result_t pending_results[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;

  vertex_store_transform u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // rounded fixed-point product, floor shift of the rounded value
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b + (64'sd1 <<< (vst_pkg::FRAC_BITS - 1));
    return p >>> vst_pkg::FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // predict one operation and update the model table
  function automatic vtx_result_t predict_vertex_op(input logic [2:0] fn,
      input logic [9:0] id, input logic signed [31:0] pa, input logic signed [31:0] pb,
      input logic signed [31:0] pc, input logic signed [31:0] pd);
    vtx_result_t r;
    logic signed [63:0] tx, ty, tz, a, b, c, d, one;
    logic signed [63:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
    logic signed [63:0] m [9];
    logic signed [31:0] nx, ny, nz;
    logic ok;
    r = '0;
    r.rid = id;
    ok = id < vcount;
    a = pa; b = pb; c = pc; d = pd;
    if (fn == vst_pkg::FN_APPEND || fn == vst_pkg::FN_COPY) begin
      if (fn == vst_pkg::FN_COPY && !ok) begin
        r.status = vst_pkg::ST_BAD_ID;
        return r;
      end
      if (fn == vst_pkg::FN_COPY) begin
        nx = tab_x[id]; ny = tab_y[id]; nz = tab_z[id];
      end else begin
        nx = pa; ny = pb; nz = pc;
      end
      if (vcount >= vst_pkg::MAX_VERTICES) begin
        r.status = vst_pkg::ST_FULL;
        return r;
      end
      tab_x[vcount] = nx; tab_y[vcount] = ny; tab_z[vcount] = nz;
      r.status = vst_pkg::ST_OK; r.rid = vcount[9:0]; r.x = nx; r.y = ny; r.z = nz;
      vcount++;
      return r;
    end
    if (fn > vst_pkg::FN_ROTATE || !ok) begin
      r.status = vst_pkg::ST_BAD_ID;
      return r;
    end
    tx = tab_x[id]; ty = tab_y[id]; tz = tab_z[id];
    case (fn)
      vst_pkg::FN_READ: begin
        nx = tx; ny = ty; nz = tz;
      end
      vst_pkg::FN_TRANSLATE: begin
        nx = clamp32(tx + a); ny = clamp32(ty + b); nz = clamp32(tz + c);
      end
      vst_pkg::FN_SCALE: begin
        nx = clamp32(qmul(tx, a)); ny = clamp32(qmul(ty, b)); nz = clamp32(qmul(tz, c));
      end
      default: begin
        one = 64'sd1 <<< vst_pkg::FRAC_BITS;
        xx = qmul(a, a); yy = qmul(b, b); zz = qmul(c, c);
        xy = qmul(a, b); xz = qmul(a, c); yz = qmul(b, c);
        xw = qmul(a, d); yw = qmul(b, d); zw = qmul(c, d);
        m[0] = clamp32(one - 2 * (yy + zz));
        m[1] = clamp32(2 * (xy - zw));
        m[2] = clamp32(2 * (xz + yw));
        m[3] = clamp32(2 * (xy + zw));
        m[4] = clamp32(one - 2 * (xx + zz));
        m[5] = clamp32(2 * (yz - xw));
        m[6] = clamp32(2 * (xz - yw));
        m[7] = clamp32(2 * (yz + xw));
        m[8] = clamp32(one - 2 * (xx + yy));
        nx = clamp32(qmul(tx, m[0]) + qmul(ty, m[1]) + qmul(tz, m[2]));
        ny = clamp32(qmul(tx, m[3]) + qmul(ty, m[4]) + qmul(tz, m[5]));
        nz = clamp32(qmul(tx, m[6]) + qmul(ty, m[7]) + qmul(tz, m[8]));
      end
    endcase
    tab_x[id] = nx; tab_y[id] = ny; tab_z[id] = nz;
    r.status = vst_pkg::ST_OK; r.x = nx; r.y = ny; r.z = nz;
    return r;
  endfunction

  // send one beat, random idle before it, a rest with valid low after it
  task automatic send_op(input logic [2:0] fn, input logic [9:0] id,
      input logic [31:0] pa, input logic [31:0] pb, input logic [31:0] pc,
      input logic [31:0] pd);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, pd, pc, pb, pa, id, fn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_vertex_op(fn, id, pa, pb, pc, pd));
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    vtx_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[vst_pkg::OUT_W-1-4:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.rid !== want.rid || got.x !== want.x ||
            got.y !== want.y || got.z !== want.z) begin
          $display("%0t: mismatch expected st=%0d id=%0d %h %h %h actual st=%0d id=%0d %h %h %h",
                   $time, want.status, want.rid, want.x, want.y, want.z,
                   got.status, got.rid, got.x, got.y, got.z);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h80000000 | $urandom_range(3);
      2: return 32'h7fffffff - $urandom_range(3);
      default: return $urandom_range(32'h1fffff) - 32'h100000;
    endcase
  endfunction

  // quaternion components between -1.0 and 1.0, or raw noise
  function automatic logic [31:0] rand_quat();
    if ($urandom_range(7) == 0) return $urandom();
    return $urandom_range(32'h20000) - 32'h10000;
  endfunction

  function automatic logic [9:0] rand_id();
    if (vcount > 0 && $urandom_range(9) != 0) return 10'($urandom_range(vcount - 1));
    return 10'($urandom());
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(vst_pkg::FN_READ, 10'd0, 0, 0, 0, 0);
    send_op(vst_pkg::FN_APPEND, 10'd0, 32'h00010000, 32'h00020000, 32'hfffd0000, 0);
    send_op(vst_pkg::FN_APPEND, 10'd1023, 32'h7fffffff, 32'h80000000, 32'hffffffff,
            32'hffffffff);
    send_op(vst_pkg::FN_COPY, 10'd0, 0, 0, 0, 0);
    send_op(vst_pkg::FN_COPY, 10'd3, 0, 0, 0, 0);
    send_op(vst_pkg::FN_COPY, 10'd1023, 0, 0, 0, 0);
    send_op(vst_pkg::FN_READ, 10'd1, 0, 0, 0, 0);
    send_op(vst_pkg::FN_TRANSLATE, 10'd1, 32'h7fffffff, 32'h80000000, 32'h00010000, 0);
    send_op(vst_pkg::FN_TRANSLATE, 10'd3, 0, 0, 0, 0);
    send_op(vst_pkg::FN_SCALE, 10'd0, 32'h00020000, 32'hffff0000, 32'h00008000, 0);
    send_op(vst_pkg::FN_SCALE, 10'd1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
    send_op(vst_pkg::FN_ROTATE, 10'd0, 0, 0, 32'h0000b505, 32'h0000b505);
    send_op(vst_pkg::FN_ROTATE, 10'd2, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000);
    send_op(vst_pkg::FN_ROTATE, 10'd0, 0, 0, 0, 32'h00010000);
    send_op(3'd6, 10'd0, 0, 0, 0, 0);
    send_op(3'd7, 10'd1023, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_op(vst_pkg::FN_ROTATE, 10'd5, 0, 0, 0, 0);
  endtask

  // random mix of ops, with some bad function codes and out-of-range ids
  task automatic test_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0, 1, 2: send_op(vst_pkg::FN_APPEND, 10'($urandom()), rand_coord(), rand_coord(),
                         rand_coord(), $urandom());
        3: send_op(vst_pkg::FN_COPY, rand_id(), $urandom(), $urandom(), $urandom(),
                   $urandom());
        4, 5: send_op(vst_pkg::FN_READ, rand_id(), $urandom(), $urandom(), $urandom(),
                      $urandom());
        6, 7, 8: send_op(vst_pkg::FN_TRANSLATE, rand_id(), rand_coord(), rand_coord(),
                         rand_coord(), $urandom());
        9, 10, 11: send_op(vst_pkg::FN_SCALE, rand_id(), rand_coord(), rand_coord(),
                           rand_coord(), $urandom());
        12: send_op(3'($urandom_range(6, 7)), 10'($urandom()), $urandom(), $urandom(),
                    $urandom(), $urandom());
        default: send_op(vst_pkg::FN_ROTATE, rand_id(), rand_quat(), rand_quat(),
                         rand_quat(), rand_quat());
      endcase
    end
  endtask

  // fill the table to the top, then hit the full case
  task automatic test_table_full();
    while (vcount < vst_pkg::MAX_VERTICES)
      send_op($urandom_range(1) ? vst_pkg::FN_APPEND : vst_pkg::FN_COPY, rand_id(),
              rand_coord(), rand_coord(), rand_coord(), $urandom());
    send_op(vst_pkg::FN_APPEND, 10'd0, 1, 2, 3, 4);
    send_op(vst_pkg::FN_COPY, 10'd1023, 0, 0, 0, 0);
    send_op(vst_pkg::FN_COPY, 10'd0, 0, 0, 0, 0);
    send_op(vst_pkg::FN_ROTATE, 10'd1023, rand_quat(), rand_quat(), rand_quat(),
            rand_quat());
    send_op(vst_pkg::FN_READ, 10'd1023, 0, 0, 0, 0);
  endtask

  initial begin
    int w;
    vcount = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle = 0; recv_stall = 0;
    test_random(300);
    send_idle = 56; recv_stall = 0;
    test_random(300);
    // hold off until everything is back
    wait_drained();
    send_idle = 0; recv_stall = 56;
    test_random(300);
    send_idle = 8; recv_stall = 8;
    test_random(200);
    send_idle = 0; recv_stall = 0;
    test_table_full();
    send_idle = 56; recv_stall = 56;
    test_random(80);
    wait_drained();
    for (w = 0; w < 20; w++) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
